FILE: rtl/tld_pkg.sv
`timescale 1ns / 1ps

package tld_pkg;

  // Line store geometry.
  localparam int LINE_CHARS = 32;
  localparam int LEN_W      = $clog2(LINE_CHARS + 1);
  localparam int IDX_W      = $clog2(LINE_CHARS);
  localparam int CFG_IDX_W  = 3;

  // Character codes.
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] CR_BYTE  = 8'h0D;
  localparam logic [7:0] ESC_BYTE = 8'h5C;
  localparam logic [7:0] UC_A     = 8'h41;
  localparam logic [7:0] UC_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Reset values of the settings.
  localparam logic [7:0] ERASE_RST = 8'd35;
  localparam logic [7:0] KILL_RST  = 8'd64;

  // Word kinds and result channels.
  localparam logic KIND_KEYBOARD = 1'b0;
  localparam logic KIND_PROGRAM  = 1'b1;
  localparam logic CHAN_DISPLAY  = 1'b0;
  localparam logic CHAN_LINE     = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_MODE  = 3'd0,
    CFG_MAP_CR    = 3'd1,
    CFG_FOLD_UC   = 3'd2,
    CFG_ECHO      = 3'd3,
    CFG_ERASE     = 3'd4,
    CFG_KILL      = 3'd5
  } cfg_idx_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_EDIT,
    S_EMIT_RD,
    S_EMIT_WR
  } tld_state_t;

endpackage

FILE: rtl/tld_in_if.sv
`timescale 1ns / 1ps

interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_in;

  modport source (output valid, output kind, output char_in, input ready);
  modport sink   (input valid, input kind, input char_in, output ready);
endinterface

FILE: rtl/tld_out_if.sv
`timescale 1ns / 1ps

interface tld_out_if;
  logic       valid;
  logic       ready;
  logic       channel;
  logic [7:0] char_out;
  logic       last;
  logic       empty_line;

  modport source (output valid, output channel, output char_out, output last,
                  output empty_line, input ready);
  modport sink   (input valid, input channel, input char_out, input last,
                  input empty_line, output ready);
endinterface

FILE: rtl/tld_cfg_if.sv
`timescale 1ns / 1ps

interface tld_cfg_if
  import tld_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/terminal_line_discipline_core.sv
`timescale 1ns / 1ps

// Canonical terminal line discipline. A word on in_ch is either a keyboard
// byte or a program output byte; words on out_ch are display bytes (channel
// 0) or bytes of a completed input line (channel 1, last on the final byte,
// an empty line as one marker word with empty_line set). The typed line lives
// in a 32-byte synchronous RAM with one write and one registered read port.
// A new word is taken only when the previous one is fully handled, and a
// keyboard byte that completes a line first flushes it: one RAM read and
// one output word per stored byte, or the empty line marker. Output stalls
// can hold any display or line word. Settings are written on cfg_ch, which
// is always ready; the user must write them only while the block is idle,
// which the block itself does not enforce.
module terminal_line_discipline_core
  import tld_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tld_in_if.sink    in_ch,
  tld_out_if.source out_ch,
  tld_cfg_if.sink   cfg_ch
);

  // Settings.
  logic       raw_r, map_cr_r, fold_r, echo_r;
  logic [7:0] erase_r, kill_r;

  // Sequencer and per-word context.
  tld_state_t state_r, state_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] char_r, char_nxt;
  logic       ends_r, ends_nxt;
  logic       need_cr_r, need_cr_nxt;
  logic       need_ch_r, need_ch_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] emit_len_r, emit_len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Output register.
  logic       out_valid_r;
  logic       out_chan_r, out_last_r, out_empty_r;
  logic [7:0] out_char_r;
  logic       can_push, push;
  logic       push_chan, push_last, push_empty;
  logic [7:0] push_char;

  // Line store RAM.
  logic [7:0]       mem [LINE_CHARS];
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [7:0]       mem_wd, rd_q;

  // Decode helpers.
  logic       in_fire;
  logic [7:0] mapped, disp_char;
  logic       disp_en, disp_drop;
  logic       escaped, store;
  logic [LEN_W-1:0] len_edit, len_inc, idx_ext;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign can_push     = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.channel    = out_chan_r;
  assign out_ch.char_out   = out_char_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.empty_line = out_empty_r;

  // Keyboard byte after CR mapping and case folding.
  always_comb begin
    mapped = in_ch.char_in;
    if (map_cr_r && in_ch.char_in == CR_BYTE) begin
      mapped = LF_BYTE;
    end
    if (fold_r && mapped >= UC_A && mapped <= UC_Z) begin
      mapped = mapped + CASE_OFS;
    end
  end

  assign disp_char = (in_ch.kind == KIND_PROGRAM) ? in_ch.char_in : mapped;
  assign disp_en   = (in_ch.kind == KIND_PROGRAM) || echo_r;
  assign disp_drop = (disp_char == EOT_BYTE) && !raw_r;

  // Escape test uses the stored byte just before the insertion point.
  assign escaped = (len_r != '0) && (rd_q == ESC_BYTE);
  assign len_inc = len_r + LEN_W'(1);
  assign idx_ext = {1'b0, idx_r} + LEN_W'(1);

  // Next state and outputs of the sequencer.
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    char_nxt     = char_r;
    ends_nxt     = ends_r;
    need_cr_nxt  = need_cr_r;
    need_ch_nxt  = need_ch_r;
    len_nxt      = len_r;
    emit_len_nxt = emit_len_r;
    idx_nxt      = idx_r;
    push         = 1'b0;
    push_chan    = CHAN_DISPLAY;
    push_char    = char_r;
    push_last    = 1'b0;
    push_empty   = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = len_r[IDX_W-1:0];
    mem_wd       = char_r;
    mem_re       = 1'b0;
    mem_ra       = idx_r;
    store        = 1'b0;
    len_edit     = len_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt    = in_ch.kind;
          char_nxt    = disp_char;
          ends_nxt    = raw_r || (mapped == LF_BYTE) || (mapped == EOT_BYTE);
          need_cr_nxt = disp_en && !disp_drop && map_cr_r && (disp_char == LF_BYTE);
          need_ch_nxt = disp_en && !disp_drop && (disp_char != NUL_BYTE);
          // Fetch the previous stored byte for the escape test.
          mem_re      = 1'b1;
          mem_ra      = IDX_W'(len_r - LEN_W'(1));
          state_nxt   = S_DISP;
        end
      end

      // Up to two display words: an inserted CR, then the byte itself.
      S_DISP: begin
        if (need_cr_r) begin
          if (can_push) begin
            push        = 1'b1;
            push_char   = CR_BYTE;
            need_cr_nxt = 1'b0;
          end
        end else if (need_ch_r) begin
          if (can_push) begin
            push        = 1'b1;
            need_ch_nxt = 1'b0;
          end
        end else if (kind_r == KIND_KEYBOARD) begin
          state_nxt = S_EDIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // Line editing: erase, kill, EOT, or store the byte; a line end or a full line starts the flush.
      S_EDIT: begin
        store = 1'b1;
        if (!raw_r && !escaped) begin
          if (char_r == erase_r) begin
            store = 1'b0;
            if (len_r != '0) begin
              len_edit = len_r - LEN_W'(1);
            end
          end else if (char_r == kill_r) begin
            store    = 1'b0;
            len_edit = '0;
          end else if (char_r == EOT_BYTE) begin
            store = 1'b0;
          end
        end
        if (store) begin
          mem_we   = 1'b1;
          len_edit = len_inc;
        end
        if (ends_r || (store && len_inc >= LEN_W'(LINE_CHARS))) begin
          emit_len_nxt = len_edit;
          len_nxt      = '0;
          idx_nxt      = '0;
          state_nxt    = S_EMIT_RD;
        end else begin
          len_nxt   = len_edit;
          state_nxt = S_IDLE;
        end
      end

      // Line flush: empty marker, or one RAM read per stored byte.
      S_EMIT_RD: begin
        if (emit_len_r == '0) begin
          if (can_push) begin
            push       = 1'b1;
            push_chan  = CHAN_LINE;
            push_char  = NUL_BYTE;
            push_last  = 1'b1;
            push_empty = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_EMIT_WR;
        end
      end

      S_EMIT_WR: begin
        if (can_push) begin
          push      = 1'b1;
          push_chan = CHAN_LINE;
          push_char = rd_q;
          push_last = (idx_ext == emit_len_r);
          if (idx_ext == emit_len_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer and line length registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  // Per-word context.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    char_r     <= char_nxt;
    ends_r     <= ends_nxt;
    need_cr_r  <= need_cr_nxt;
    need_ch_r  <= need_ch_nxt;
    emit_len_r <= emit_len_nxt;
    idx_r      <= idx_nxt;
  end

  // Output register: loads when empty or when the held word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_chan_r  <= push_chan;
      out_char_r  <= push_char;
      out_last_r  <= push_last;
      out_empty_r <= push_empty;
    end
  end

  // Line store RAM with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Settings registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      map_cr_r <= 1'b1;
      fold_r   <= 1'b0;
      echo_r   <= 1'b1;
      erase_r  <= ERASE_RST;
      kill_r   <= KILL_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_RAW_MODE: raw_r    <= cfg_ch.data[0];
        CFG_MAP_CR:   map_cr_r <= cfg_ch.data[0];
        CFG_FOLD_UC:  fold_r   <= cfg_ch.data[0];
        CFG_ECHO:     echo_r   <= cfg_ch.data[0];
        CFG_ERASE:    erase_r  <= cfg_ch.data;
        CFG_KILL:     kill_r   <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/tld_checker.sv
`timescale 1ns / 1ps

module tld_checker
  import tld_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_channel,
  input logic [7:0] out_char_out,
  input logic       out_last,
  input logic       out_empty_line
);

  // One word is handled at a time: ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous word still in progress");

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char_out)
      && $stable(out_channel) && $stable(out_last) && $stable(out_empty_line)))
    else $error("stalled result word changed");

  // The empty line marker is a final line word with a zero byte; display
  // words never carry line framing.
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_empty_line || out_channel == CHAN_DISPLAY)) |->
      ((out_empty_line && out_channel == CHAN_LINE && out_last && out_char_out == NUL_BYTE)
       || (!out_empty_line && !out_last)))
    else $error("malformed display word or empty line marker");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind terminal_line_discipline_core tld_checker u_tld_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_channel    (out_ch.channel),
  .out_char_out   (out_ch.char_out),
  .out_last       (out_ch.last),
  .out_empty_line (out_ch.empty_line)
);
